// File: design/pcbm_pkg.sv
// package for the clip box measure block: codes and float compare
`default_nettype none
package pcbm_pkg;

  typedef enum logic [2:0] {
    CMD_MOVE  = 3'd0,
    CMD_LINE  = 3'd1,
    CMD_QUAD  = 3'd2,
    CMD_CUBIC = 3'd3,
    CMD_CLOSE = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    VERDICT_BOUNDED   = 2'd0,
    VERDICT_UNBOUNDED = 2'd1,
    VERDICT_INVALID   = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    REG_MIN_X = 2'd0,
    REG_MIN_Y = 2'd1,
    REG_MAX_X = 2'd2,
    REG_MAX_Y = 2'd3
  } reg_e;

  localparam int unsigned OUT_INDEX_BITS = 24;

  function automatic logic f32_is_nan(input logic [31:0] a);
    f32_is_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
  endfunction

  // a <= b under ieee single compare, false on nan
  function automatic logic f32_le(input logic [31:0] a, input logic [31:0] b);
    logic res;
    res = 1'b0;
    if (f32_is_nan(a) || f32_is_nan(b)) begin
      res = 1'b0;
    end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      res = 1'b1;
    end else if (a[31] != b[31]) begin
      res = a[31];
    end else if (!a[31]) begin
      res = (a[30:0] <= b[30:0]);
    end else begin
      res = (a[30:0] >= b[30:0]);
    end
    f32_le = res;
  endfunction

endpackage
`default_nettype wire

// File: design/pcbm_box_check.sv
// vertex inside clip box test with four float compares
`default_nettype none
module pcbm_box_check
  import pcbm_pkg::*;
(
  input  wire logic [31:0] vertex_x_i,
  input  wire logic [31:0] vertex_y_i,
  input  wire logic [31:0] min_x_i,
  input  wire logic [31:0] min_y_i,
  input  wire logic [31:0] max_x_i,
  input  wire logic [31:0] max_y_i,
  output logic             inside_o
);
  assign inside_o = f32_le(min_x_i, vertex_x_i) && f32_le(min_y_i, vertex_y_i) &&
                    f32_le(vertex_x_i, max_x_i) && f32_le(vertex_y_i, max_y_i);
endmodule
`default_nettype wire

// File: design/path_clip_box_measure.sv
// top level of the path clip box measure block
//
//  channel | direction | handshake         | word
//  in      | input     | in_valid/in_stall | command, vertex, last flag
//  out     | output    | out_valid/out_stall | verdict, index, move point
//  cfg     | input     | cfg_valid/cfg_ready | register index and data
//
// one word per cycle while in_stall is low; an input word is registered, checked in the next cycle
// and, for the last word of a path, its result goes to the output register as the word moves on.
// reset clears path state, clip box and move point to zero.
// a stalled output blocks the input only when a result is held and the
// pending word would produce another one.
`default_nettype none
module path_clip_box_measure
  import pcbm_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [31:0] vertex_x_i,
  input  wire logic [31:0] vertex_y_i,
  input  wire logic        last_element_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       verdict_o,
  output logic [23:0]      first_out_index_o,
  output logic [31:0]      last_move_x_o,
  output logic [31:0]      last_move_y_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  logic [31:0] min_x_q, min_y_q, max_x_q, max_y_q;

  // input register
  logic        iv_q;
  logic [2:0]  cmd_q;
  logic [31:0] vx_q, vy_q;
  logic        last_q;

  // path state
  logic                  open_q, open_d;
  logic [1:0]            grem_q, grem_d;
  logic [INDEX_BITS-1:0] gidx_q, gidx_d;
  logic [INDEX_BITS-1:0] cnt_q;
  logic                  dec_q, dec_d;
  verdict_e              lv_q, lv_d;
  logic [INDEX_BITS-1:0] lidx_q, lidx_d;
  logic [31:0]           mx_q, mx_d, my_q, my_d;

  logic ov_q;
  verdict_e              ver_d;
  logic [23:0]           fidx_d;
  logic [31:0]           ux;
  logic in_box, stage_go, in_acc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= '0;
      min_y_q <= '0;
      max_x_q <= '0;
      max_y_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_MIN_X: min_x_q <= cfg_data_i;
        REG_MIN_Y: min_y_q <= cfg_data_i;
        REG_MAX_X: max_x_q <= cfg_data_i;
        REG_MAX_Y: max_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // staged word moves on unless it makes a result that cannot be stored
  assign stage_go   = iv_q && !(last_q && ov_q && out_stall_i);
  assign in_stall_o = iv_q && !stage_go;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (in_acc) begin
      iv_q <= 1'b1;
    end else if (stage_go) begin
      iv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= command_i;
      vx_q   <= vertex_x_i;
      vy_q   <= vertex_y_i;
      last_q <= last_element_i;
    end
  end

  pcbm_box_check u_check (
    .vertex_x_i (vx_q),
    .vertex_y_i (vy_q),
    .min_x_i    (min_x_q),
    .min_y_i    (min_y_q),
    .max_x_i    (max_x_q),
    .max_y_i    (max_y_q),
    .inside_o   (in_box)
  );

  always_comb begin
    open_d = open_q;
    grem_d = grem_q;
    gidx_d = gidx_q;
    dec_d  = dec_q;
    lv_d   = lv_q;
    lidx_d = lidx_q;
    mx_d   = mx_q;
    my_d   = my_q;
    if (!dec_q) begin
      if (grem_q != 2'd0) begin
        if (!in_box) begin
          dec_d  = 1'b1;
          lv_d   = VERDICT_UNBOUNDED;
          lidx_d = gidx_q;
        end
        grem_d = grem_q - 2'd1;
      end else begin
        case (cmd_q)
          CMD_MOVE: begin
            mx_d   = vx_q;
            my_d   = vy_q;
            open_d = 1'b1;
            if (!in_box) begin
              dec_d  = 1'b1;
              lv_d   = VERDICT_UNBOUNDED;
              lidx_d = cnt_q;
            end
          end
          CMD_LINE, CMD_QUAD, CMD_CUBIC: begin
            if (!open_q) begin
              dec_d  = 1'b1;
              lv_d   = VERDICT_INVALID;
              lidx_d = '0;
            end else begin
              if (cmd_q != CMD_LINE) begin
                gidx_d = cnt_q;
                grem_d = cmd_q[1:0] - 2'd1;
              end
              if (!in_box) begin
                dec_d  = 1'b1;
                lv_d   = VERDICT_UNBOUNDED;
                lidx_d = cnt_q;
              end
            end
          end
          CMD_CLOSE: open_d = 1'b0;
          default: begin
            dec_d  = 1'b1;
            lv_d   = VERDICT_INVALID;
            lidx_d = '0;
          end
        endcase
      end
    end
  end

  // widen index to 32 bits, then keep the low 24
  assign ux = 32'(lidx_d);

  always_comb begin
    fidx_d = '0;
    if (dec_d) begin
      ver_d = lv_d;
      if (lv_d == VERDICT_UNBOUNDED) fidx_d = ux[23:0];
    end else if (grem_d != 2'd0) begin
      ver_d = VERDICT_INVALID;
    end else begin
      ver_d = VERDICT_BOUNDED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      grem_q <= '0;
      gidx_q <= '0;
      cnt_q  <= '0;
      dec_q  <= 1'b0;
      lv_q   <= VERDICT_BOUNDED;
      lidx_q <= '0;
      mx_q   <= '0;
      my_q   <= '0;
    end else if (stage_go) begin
      mx_q <= mx_d;
      my_q <= my_d;
      if (last_q) begin
        open_q <= 1'b0;
        grem_q <= '0;
        gidx_q <= '0;
        cnt_q  <= '0;
        dec_q  <= 1'b0;
        lv_q   <= VERDICT_BOUNDED;
        lidx_q <= '0;
      end else begin
        open_q <= open_d;
        grem_q <= grem_d;
        gidx_q <= gidx_d;
        cnt_q  <= cnt_q + 1'b1;
        dec_q  <= dec_d;
        lv_q   <= lv_d;
        lidx_q <= lidx_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (stage_go && last_q) begin
      ov_q <= 1'b1;
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_go && last_q) begin
      verdict_o         <= ver_d;
      first_out_index_o <= fidx_d;
      last_move_x_o     <= mx_d;
      last_move_y_o     <= my_d;
    end
  end

  assign out_valid_o = ov_q;

endmodule
`default_nettype wire

// File: design/pcbm_checker.sv
// port level checks for the path clip box measure block
`default_nettype none
module pcbm_checker
  import pcbm_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  verdict_o,
  input wire logic [23:0] first_out_index_o,
  input wire logic        cfg_ready_o
);
  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (verdict_o != 2'd3))
    else $error("verdict code out of range");

  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && verdict_o != VERDICT_UNBOUNDED) |-> (first_out_index_o == 24'd0))
    else $error("index set on non unbounded verdict");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(verdict_o)))
    else $error("stalled result changed");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");
endmodule

bind path_clip_box_measure pcbm_checker u_pcbm_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .verdict_o         (verdict_o),
  .first_out_index_o (first_out_index_o),
  .cfg_ready_o       (cfg_ready_o)
);
`default_nettype wire
